// ===== hw/rtl/k_nearest_max_heap_select_macros.svh =====
// ----------------------------------------------------------------------------
// k_nearest_max_heap_select assertion macros
// Short forms for the concurrent checks on the selector ports.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_MAX_HEAP_SELECT_MACROS_SVH
`define K_NEAREST_MAX_HEAP_SELECT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define KNMHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("k_nearest_max_heap_select check failed");

// Condition must never be seen at a clock edge
`define KNMHS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("k_nearest_max_heap_select check failed");

`endif

// ===== hw/rtl/knmhs_pkg.sv =====
// ----------------------------------------------------------------------------
// knmhs_pkg
// Shared types and field widths of the nearest-neighbour selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package knmhs_pkg;

    localparam int DIST_W  = 32;
    localparam int LABEL_W = 16;

    // One kept candidate as stored in the entry memory
    typedef struct packed {
        logic [DIST_W-1:0]  sq_dist;
        logic [LABEL_W-1:0] label;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hw/rtl/knmhs_ram.sv =====
// ----------------------------------------------------------------------------
// knmhs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knmhs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 20,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/k_nearest_max_heap_select.sv =====
// ----------------------------------------------------------------------------
// k_nearest_max_heap_select
// Bounded top-K nearest-neighbour selector over a stream of candidates.
// ----------------------------------------------------------------------------
// The block keeps the NEIGHBOURS candidates with the smallest distance,
// sorted by (distance, arrival), in one entry RAM. A candidate is inserted by
// walking down from the tail one entry per cycle: the single RAM read port
// and one 32-bit magnitude comparator move one entry up per cycle until the
// slot is found. While not full, a candidate goes into an empty store
// straight at the head in S_RD, and otherwise S_RD starts a read and S_CMP
// steps down past each larger kept entry; once full, S_FCHK first compares
// it against the greatest kept entry, and a candidate that is not strictly
// smaller is dropped. in_ready is high only while the block is idle. On a
// beat with last set, the kept entries follow in ascending order, with
// final_res on the final one; the store is then empty for the next query.
`timescale 1ns / 1ps
`default_nettype none

module k_nearest_max_heap_select #(
    parameter int NEIGHBOURS = 20
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [knmhs_pkg::DIST_W-1:0]  distance,
    input  wire logic [knmhs_pkg::LABEL_W-1:0] label,
    input  wire logic                         last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [knmhs_pkg::DIST_W-1:0]  nearest_distance,
    output logic      [knmhs_pkg::LABEL_W-1:0] nearest_label,
    output logic                              final_res
);

    localparam int AW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int CW = $clog2(NEIGHBOURS + 1);

    localparam logic [AW-1:0] LAST_POS = AW'(NEIGHBOURS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NEIGHBOURS);

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FCHK = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_ERD  = 3'd4;
    localparam logic [2:0] S_ELD  = 3'd5;
    localparam logic [2:0] S_EOUT = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [knmhs_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic [knmhs_pkg::LABEL_W-1:0]  label_reg, label_next;
    logic                           last_reg, last_next;
    logic                           out_valid_reg, out_valid_next;
    logic [knmhs_pkg::DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [knmhs_pkg::LABEL_W-1:0]  out_label_reg, out_label_next;
    logic                           final_reg, final_next;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    knmhs_pkg::entry_t              ram_wdata;
    knmhs_pkg::entry_t              ram_rdata;
    logic [knmhs_pkg::ENTRY_W-1:0]  ram_rdata_raw;
    knmhs_pkg::entry_t              new_entry;
    logic                           rd_greater;
    logic                           in_beat;

    knmhs_ram #(
        .WIDTH (knmhs_pkg::ENTRY_W),
        .DEPTH (NEIGHBOURS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = ram_rdata_raw;
    assign new_entry = '{sq_dist: dist_reg, label: label_reg};

    // Shared comparator: kept entry against the held candidate
    assign rd_greater = ram_rdata.sq_dist > dist_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;

    // Sequencer and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        dist_next      = dist_reg;
        label_next     = label_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_label_next = out_label_reg;
        final_next     = final_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = new_entry;
        ram_raddr      = LAST_POS;

        case (state_reg)
            S_IDLE:
            begin
                // Greatest kept entry is read here for the full check
                if (in_beat)
                begin
                    dist_next  = distance;
                    label_next = label;
                    last_next  = last;
                    if (count_reg < FULL_CNT)
                    begin
                        pos_next   = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_FCHK;
                    end
                end
            end

            S_FCHK:
            begin
                // Replace the tail only on a strictly smaller distance
                if (rd_greater)
                begin
                    pos_next   = LAST_POS;
                    state_next = S_RD;
                end
                else if (last_reg)
                begin
                    pos_next   = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_RD:
            begin
                if (pos_reg == '0)
                begin
                    // Place the candidate at the head
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    if (last_reg)
                    begin
                        state_next = S_ERD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_raddr  = pos_reg - AW'(1);
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                ram_we = 1'b1;
                if (rd_greater)
                begin
                    // Move the larger entry up one slot; read the next one down, if any
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        ram_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    // Slot found: place the candidate after equal distances
                    pos_next = '0;
                    if (last_reg)
                    begin
                        state_next = S_ERD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_ERD:
            begin
                ram_raddr  = pos_reg;
                state_next = S_ELD;
            end

            S_ELD:
            begin
                // Load the output register from the entry just read
                out_valid_next = 1'b1;
                out_dist_next  = ram_rdata.sq_dist;
                out_label_next = ram_rdata.label;
                final_next     = (CW'(pos_reg) == count_reg - CW'(1));
                state_next     = S_EOUT;
            end

            S_EOUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (final_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_raddr  = pos_reg + AW'(1);
                        pos_next   = pos_reg + AW'(1);
                        state_next = S_ELD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dist_reg      <= dist_next;
        label_reg     <= label_next;
        last_reg      <= last_next;
        out_dist_reg  <= out_dist_next;
        out_label_reg <= out_label_next;
        final_reg     <= final_next;
    end

    assign out_valid        = out_valid_reg;
    assign nearest_distance = out_dist_reg;
    assign nearest_label    = out_label_reg;
    assign final_res        = final_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/knmhs_check.sv =====
// ----------------------------------------------------------------------------
// knmhs_check
// Port-level checks on the nearest-neighbour selector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "k_nearest_max_heap_select_macros.svh"

module knmhs_check (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          last,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [knmhs_pkg::DIST_W-1:0]  nearest_distance,
    input wire logic [knmhs_pkg::LABEL_W-1:0] nearest_label,
    input wire logic                          final_res
);

    // Intake and emission never overlap
    `KNMHS_ASSERT_NEVER(a_no_in_during_out, in_ready && out_valid)

    // A beat without last produces no result
    `KNMHS_ASSERT_NEXT(a_quiet_after_mid, in_valid && in_ready && !last, !out_valid)

    // Emission ends after the final result is taken
    `KNMHS_ASSERT_NEXT(a_end_after_final, out_valid && out_ready && final_res, !out_valid)

    // Stalled result holds
    `KNMHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Stalled result payload holds
    `KNMHS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(nearest_distance) && $stable(nearest_label) && $stable(final_res))

endmodule

bind k_nearest_max_heap_select knmhs_check u_knmhs_check (.*);

`default_nettype wire
